[hdl/sbd_pkg.sv]
// Package for the snappy block decompressor: widths, status codes, parse phases
// and the word types passed from the front parser to the copy engine.
// No dependencies.
package sbd_pkg;

    localparam int MaxBlockBytes = 65536;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_LIT_TRUNC = 3'd2,
        ST_LIT_OVER  = 3'd3,
        ST_CPY_TRUNC = 3'd4,
        ST_CPY_BAD   = 3'd5,
        ST_LEN_MISM  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        PH_LEN    = 3'd0,
        PH_TAG    = 3'd1,
        PH_LITEXT = 3'd2,
        PH_LITDAT = 3'd3,
        PH_COPY1  = 3'd4,
        PH_COPY2  = 3'd5,
        PH_COPY4  = 3'd6,
        PH_ERR    = 3'd7
    } t_phase;

    // front -> back command word; cpy_off is 21 bits, so offsets below 2 MiB
    typedef struct packed {
        logic        lit;      // emit data_byte as literal
        logic        cpy;      // replay cpy_len bytes from distance cpy_off
        logic [6:0]  cpy_len;
        logic [20:0] cpy_off;
        logic [7:0]  data_byte;
        logic        fin;      // block end on this input
        logic [2:0]  status;
    } t_cmd;

endpackage

[hdl/sbd_front.sv]
// Front parser of the snappy block decompressor: varint, tags, offsets, checks.
// Depends on sbd_pkg. Produces at most one command word per input word.
module sbd_front #(
    parameter int MAX_BLOCK_BYTES = sbd_pkg::MaxBlockBytes,
    parameter int CW = $clog2(MAX_BLOCK_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_valid,
    input  logic          i_ready,
    output sbd_pkg::t_cmd o_cmd
);
    sbd_pkg::t_phase r_ph, n_ph;
    logic [CW-1:0]   r_decl, n_decl, r_prod, n_prod;
    logic [3:0]      r_vsh, n_vsh;
    logic [31:0]     r_rem, n_rem;
    logic [2:0]      r_xi, n_xi;
    logic [6:0]      r_clen, n_clen;
    logic [31:0]     r_coff, n_coff;
    logic [2:0]      r_err, n_err;
    logic            r_ov;
    sbd_pkg::t_cmd   r_cmd, n_cmd;

    logic            acc;
    logic [5:0]      hi;
    logic [CW-1:0]   room;
    logic [20:0]     vacc;
    logic [32:0]     llen;
    logic [2:0]      need;

    assign o_ready = !r_ov || i_ready;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_cmd   = r_cmd;
    assign hi      = i_byte[7:2];
    assign room    = r_decl - r_prod;

    always_comb begin
        n_ph = r_ph; n_decl = r_decl; n_prod = r_prod; n_vsh = r_vsh;
        n_rem = r_rem; n_xi = r_xi; n_clen = r_clen; n_coff = r_coff; n_err = r_err;
        n_cmd = '0;
        vacc = '0;
        llen = '0;
        need = 3'd4;
        case (r_ph)
            sbd_pkg::PH_LEN: begin
                vacc = 21'(r_decl);
                if (r_vsh < 4'd3)
                    vacc = 21'(r_decl) | (21'(i_byte[6:0]) << (5'd7 * 5'(r_vsh)));
                if (r_vsh >= 4'd3 && i_byte[6:0] != 7'd0) begin
                    n_ph = sbd_pkg::PH_ERR; n_err = sbd_pkg::ST_BAD_LEN;
                end else if (i_byte[7]) begin
                    if (r_vsh >= 4'd9) begin
                        n_ph = sbd_pkg::PH_ERR; n_err = sbd_pkg::ST_BAD_LEN;
                    end else begin
                        n_vsh = r_vsh + 4'd1;
                        n_decl = vacc > 21'(MAX_BLOCK_BYTES) ? CW'(MAX_BLOCK_BYTES)
                                                             : CW'(vacc);
                        if (vacc > 21'(MAX_BLOCK_BYTES)) n_vsh = 4'd15;
                    end
                end else if (vacc > 21'(MAX_BLOCK_BYTES) || r_vsh == 4'd15) begin
                    n_ph = sbd_pkg::PH_ERR; n_err = sbd_pkg::ST_BAD_LEN;
                end else begin
                    n_decl = CW'(vacc); n_prod = '0; n_ph = sbd_pkg::PH_TAG;
                end
            end
            sbd_pkg::PH_TAG: begin
                case (i_byte[1:0])
                    2'd0: begin
                        if (hi < 6'd60) begin
                            if (CW'(hi) + CW'(1) > room) begin
                                n_ph = sbd_pkg::PH_ERR; n_err = sbd_pkg::ST_LIT_OVER;
                            end else begin
                                n_rem = 32'(hi) + 32'd1; n_ph = sbd_pkg::PH_LITDAT;
                            end
                        end else begin
                            n_clen = 7'(hi - 6'd59); n_xi = '0; n_rem = '0;
                            n_ph = sbd_pkg::PH_LITEXT;
                        end
                    end
                    2'd1: begin
                        n_clen = 7'd4 + 7'(hi[2:0]);
                        n_coff = 32'(i_byte[7:5]) << 8; n_xi = '0;
                        n_ph = sbd_pkg::PH_COPY1;
                    end
                    default: begin
                        n_clen = 7'd1 + 7'(hi); n_coff = '0; n_xi = '0;
                        n_ph = i_byte[0] ? sbd_pkg::PH_COPY4 : sbd_pkg::PH_COPY2;
                    end
                endcase
            end
            sbd_pkg::PH_LITEXT: begin
                n_rem = r_rem | (32'(i_byte) << {r_xi[1:0], 3'b000});
                n_xi = r_xi + 3'd1;
                if (7'(n_xi) >= r_clen) begin
                    llen = 33'(n_rem) + 33'd1;
                    if (llen > 33'(room)) begin
                        n_ph = sbd_pkg::PH_ERR; n_err = sbd_pkg::ST_LIT_OVER;
                    end else begin
                        n_rem = llen[31:0]; n_ph = sbd_pkg::PH_LITDAT;
                    end
                end
            end
            sbd_pkg::PH_LITDAT: begin
                n_cmd.lit = 1'b1; n_cmd.data_byte = i_byte;
                n_prod = r_prod + CW'(1);
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) n_ph = sbd_pkg::PH_TAG;
            end
            sbd_pkg::PH_COPY1, sbd_pkg::PH_COPY2, sbd_pkg::PH_COPY4: begin
                need = (r_ph == sbd_pkg::PH_COPY1) ? 3'd1 :
                       (r_ph == sbd_pkg::PH_COPY2) ? 3'd2 : 3'd4;
                n_coff = r_coff | (32'(i_byte) << {r_xi[1:0], 3'b000});
                n_xi = r_xi + 3'd1;
                if (n_xi >= need) begin
                    if (n_coff == 32'd0 || n_coff > 32'(r_prod) || CW'(r_clen) > room) begin
                        n_ph = sbd_pkg::PH_ERR; n_err = sbd_pkg::ST_CPY_BAD;
                    end else begin
                        n_cmd.cpy = 1'b1; n_cmd.cpy_len = r_clen;
                        n_cmd.cpy_off = 21'(n_coff);
                        n_prod = r_prod + CW'(r_clen);
                        n_ph = sbd_pkg::PH_TAG;
                    end
                end
            end
            default: ;
        endcase
        if (i_last) begin
            n_cmd.fin = 1'b1;
            case (n_ph)
                sbd_pkg::PH_LEN:    n_cmd.status = sbd_pkg::ST_BAD_LEN;
                sbd_pkg::PH_TAG:    n_cmd.status = (n_prod == n_decl) ? sbd_pkg::ST_OK
                                                                      : sbd_pkg::ST_LEN_MISM;
                sbd_pkg::PH_LITEXT: n_cmd.status = sbd_pkg::ST_LIT_TRUNC;
                sbd_pkg::PH_LITDAT: n_cmd.status = sbd_pkg::ST_LIT_OVER;
                sbd_pkg::PH_ERR:    n_cmd.status = n_err;
                default:            n_cmd.status = sbd_pkg::ST_CPY_TRUNC;
            endcase
            n_ph = sbd_pkg::PH_LEN; n_decl = '0; n_prod = '0; n_vsh = '0;
            n_rem = '0; n_xi = '0; n_clen = '0; n_coff = '0; n_err = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= sbd_pkg::PH_LEN; r_decl <= '0; r_prod <= '0; r_vsh <= '0;
            r_rem <= '0; r_xi <= '0; r_clen <= '0; r_coff <= '0; r_err <= '0;
            r_ov <= 1'b0;
        end else begin
            if (acc) begin
                r_ph <= n_ph; r_decl <= n_decl; r_prod <= n_prod; r_vsh <= n_vsh;
                r_rem <= n_rem; r_xi <= n_xi; r_clen <= n_clen; r_coff <= n_coff;
                r_err <= n_err;
                r_ov <= n_cmd.lit || n_cmd.cpy || n_cmd.fin;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_cmd <= n_cmd;
    end
endmodule

[hdl/sbd_queue.sv]
// Short command queue between the front parser and the copy engine.
// Depends on sbd_pkg.
module sbd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output sbd_pkg::t_cmd o_cmd
);
    localparam int AW = $clog2(DEPTH);
    sbd_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            wr, rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end
endmodule

[hdl/sbd_back.sv]
// Copy engine of the snappy block decompressor: history memory and output words.
// Depends on sbd_pkg. Takes a new command only when idle, after any copy is done.
module sbd_back #(
    parameter int MAX_BLOCK_BYTES = sbd_pkg::MaxBlockBytes,
    parameter int AW = $clog2(MAX_BLOCK_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_dv,
    output logic          o_end,
    output logic [2:0]    o_status,
    output logic          o_last
);
    typedef enum logic [1:0] {S_IDLE, S_RD, S_OUT} t_state;
    t_state        r_st;
    logic [7:0]    r_hist [MAX_BLOCK_BYTES];
    logic [AW:0]   r_wptr;
    logic [AW-1:0] r_src;
    logic [6:0]    r_left;
    logic          r_fin;
    logic [2:0]    r_stat;
    logic [7:0]    r_rd;
    logic          r_ov, r_dv, r_end, r_last;
    logic [7:0]    r_ob;
    logic [2:0]    r_os;
    logic          out_free, wr_en, ld_word, cpy_done;
    logic [7:0]    wr_dat;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_st == S_IDLE) && out_free;
    assign o_valid  = r_ov;
    assign o_byte   = r_ob;
    assign o_dv     = r_dv;
    assign o_end    = r_end;
    assign o_status = r_os;
    assign o_last   = r_last;
    assign ld_word  = out_free && ((r_st == S_IDLE && i_valid && !i_cmd.cpy)
                                   || r_st == S_OUT);
    assign cpy_done = r_left == 7'd1;

    always_comb begin
        wr_en = 1'b0;
        wr_dat = i_cmd.data_byte;
        if (r_st == S_IDLE && i_valid && out_free && i_cmd.lit) wr_en = 1'b1;
        if (r_st == S_OUT && out_free) begin
            wr_en = 1'b1; wr_dat = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_hist[r_src];
        if (wr_en && !r_wptr[AW]) r_hist[r_wptr[AW-1:0]] <= wr_dat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_wptr <= '0;
            r_dv <= 1'b0; r_end <= 1'b0; r_os <= 3'd0; r_ob <= 8'd0; r_last <= 1'b0;
        end else begin
            r_ov <= ld_word || (r_ov && !i_ready);
            case (r_st)
                S_IDLE: if (i_valid && out_free) begin
                    r_fin <= i_cmd.fin; r_stat <= i_cmd.status;
                    if (i_cmd.cpy) begin
                        r_src  <= AW'(r_wptr - (AW+1)'(i_cmd.cpy_off));
                        r_left <= i_cmd.cpy_len;
                        r_st   <= S_RD;
                    end else begin
                        r_dv <= i_cmd.lit; r_ob <= i_cmd.lit ? i_cmd.data_byte : 8'd0;
                        r_end <= i_cmd.fin; r_os <= i_cmd.fin ? i_cmd.status : 3'd0;
                        r_last <= 1'b1;
                        r_wptr <= i_cmd.fin ? '0 : r_wptr + (AW+1)'(i_cmd.lit);
                    end
                end
                S_RD: r_st <= S_OUT;
                S_OUT: if (out_free) begin
                    r_dv <= 1'b1; r_ob <= r_rd;
                    r_wptr <= (cpy_done && r_fin) ? '0 : r_wptr + (AW+1)'(1);
                    r_left <= r_left - 7'd1;
                    r_src  <= r_src + AW'(1);
                    r_end  <= cpy_done && r_fin;
                    r_os   <= (cpy_done && r_fin) ? r_stat : 3'd0;
                    r_last <= cpy_done;
                    r_st   <= cpy_done ? S_IDLE : S_RD;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/snappy_block_decompressor_unit.sv]
// Top level of the raw snappy block decompressor.
// Depends on sbd_pkg, sbd_front, sbd_queue, sbd_back.
//
// Slave channel takes one compressed byte per word, tlast on the block's final
// byte. Master channel gives decoded words; tlast marks the last word caused
// by one input word. Literal bytes pass the parser's command register, the queue
// and the output register in turn; a copy occupies the copy engine byte by byte
// through the history memory read-then-write loop (registered read, then output
// and write-back), and no new command is taken until it is done. Parser words
// that produce nothing give no output word. A block-end word with no data gives
// one word with data flag 0 carrying block end and status. Reset returns parsing
// to the length header and empties the queue; the history memory is not cleared.
// When the receiver stalls, the output register holds, the queue fills and then
// the input side deasserts tready.
module snappy_block_decompressor_unit #(
    parameter int MAX_BLOCK_BYTES = sbd_pkg::MaxBlockBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, zero fill
    output logic [1:0]  m_axis_tuser,   // [0] data_valid, [1] block_end
    output logic        m_axis_tlast    // last
);
    logic          f_v, f_r, q_v, q_r, b_v, b_dv, b_end, b_last;
    sbd_pkg::t_cmd f_cmd, q_cmd;
    logic [7:0]    b_byte;
    logic [2:0]    b_st;

    sbd_front #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .o_valid(f_v), .i_ready(f_r), .o_cmd(f_cmd));

    sbd_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_cmd(f_cmd),
        .o_valid(q_v), .i_ready(q_r), .o_cmd(q_cmd));

    sbd_back #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_cmd(q_cmd),
        .o_valid(b_v), .i_ready(m_axis_tready), .o_byte(b_byte), .o_dv(b_dv),
        .o_end(b_end), .o_status(b_st), .o_last(b_last));

    assign m_axis_tvalid = b_v;
    assign m_axis_tdata  = {5'd0, b_st, b_byte};
    assign m_axis_tuser  = {b_end, b_dv};
    assign m_axis_tlast  = b_last;
endmodule

[hdl/sbd_checker.sv]
// Port checker for the snappy block decompressor top level, with its bind.
// Depends on the top level's ports only.
module sbd_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("block end without last");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[10:8] == 3'd0)
        else $error("status outside block end");
    a_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte set without data flag");
endmodule

bind snappy_block_decompressor_unit sbd_port_checker u_sbd_port_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .m_axis_tlast);
